### src/tlh_pkg.sv
// Package for the two-lane hash core: constants, op codes and shared types.
// No dependencies; used by every module in src.
package tlh_pkg;

  localparam int unsigned MaxOps = 6;
  localparam logic [63:0] HashM1 = 64'hd36463187cc70d7b;
  localparam logic [63:0] HashM2 = 64'hb597d0ceca3f6e07;
  localparam logic [29:0] IdxMax = 30'h3FFFFFFF;

  localparam logic [2:0] RegOpCount = 3'd0;
  localparam logic [2:0] RegOpKinds = 3'd1;
  // First op argument register; arguments follow in slot order.
  localparam logic [2:0] RegOpArg0  = 3'd2;

  localparam logic [3:0] OpMul    = 4'd0;
  localparam logic [3:0] OpXsl    = 4'd1;
  localparam logic [3:0] OpXsr    = 4'd2;
  localparam logic [3:0] OpXorRor = 4'd3;
  localparam logic [3:0] OpAdd    = 4'd4;
  localparam logic [3:0] OpXor    = 4'd5;
  localparam logic [3:0] OpNot    = 4'd6;
  localparam logic [3:0] OpBswap  = 4'd7;
  localparam logic [3:0] OpAddShl = 4'd8;
  localparam logic [3:0] OpSubShl = 4'd9;
  localparam logic [3:0] OpSub    = 4'd10;
  localparam logic [3:0] OpRol    = 4'd11;

  // Kind of work the back end does for one queued word.
  typedef enum logic [1:0] {
    AbsSkip = 2'd0,
    AbsH    = 2'd1,
    AbsV    = 2'd2
  } abs_kind_e;

  // One classified word as it sits in the queue.
  typedef struct packed {
    logic        first;
    logic [31:0] len;
    abs_kind_e   kind;
    logic [63:0] word;
    logic        last;
  } tlh_cmd_t;

  function automatic logic [63:0] rotr64(logic [63:0] x, logic [5:0] s);
    rotr64 = (x >> s) | (x << (7'd64 - {1'b0, s}));
  endfunction

  function automatic logic [63:0] rotl64(logic [63:0] x, logic [5:0] s);
    rotl64 = (x << s) | (x >> (7'd64 - {1'b0, s}));
  endfunction

endpackage

### src/tlh_front.sv
// Front end of the hash core: tracks word position and classifies each word.
// Depends on tlh_pkg.
module tlh_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [63:0]      data_word_i,
  input  logic [31:0]      total_len_i,
  input  logic             first_word_i,
  input  logic             last_word_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output tlh_pkg::tlh_cmd_t cmd_o
);
  import tlh_pkg::*;

  logic [29:0] idx_q, idx_d, idx;
  logic [31:0] len_q, len_d, len;
  logic [30:0] full_w;
  logic [63:0] mask;
  logic        acc;
  abs_kind_e   kind;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign acc         = in_valid_i && cmd_ready_i;

  always_comb begin
    len    = first_word_i ? total_len_i : len_q;
    idx    = first_word_i ? '0 : idx_q;
    full_w = {len[31:4], 3'b0} >> 2;
    mask   = (64'd1 << {len[2:0], 3'b0}) - 64'd1;
    kind   = AbsSkip;
    if ({1'b0, idx} < full_w) begin
      kind = idx[0] ? AbsV : AbsH;
    end else if (len[3] && {1'b0, idx} == full_w) begin
      kind = AbsH;
    end else if (len[2:0] != 3'd0 && {2'b0, idx} == len[31:3]) begin
      kind = AbsV;
    end
    cmd_o.first = first_word_i;
    cmd_o.len   = total_len_i;
    cmd_o.kind  = kind;
    cmd_o.word  = (kind == AbsV && len[2:0] != 3'd0 && {2'b0, idx} == len[31:3]
                   && {1'b0, idx} >= full_w) ? (data_word_i & mask) : data_word_i;
    cmd_o.last  = last_word_i;
    idx_d = idx_q;
    len_d = len_q;
    if (acc) begin
      len_d = len;
      idx_d = (idx < IdxMax) ? idx + 30'd1 : idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      len_q <= '0;
    end else begin
      idx_q <= idx_d;
      len_q <= len_d;
    end
  end

endmodule

### src/tlh_queue.sv
// Two-entry queue between front and back ends of the hash core.
// Depends on tlh_pkg.
module tlh_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  tlh_pkg::tlh_cmd_t wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output tlh_pkg::tlh_cmd_t rd_data_o
);
  import tlh_pkg::*;

  tlh_cmd_t    mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

### src/tlh_back.sv
// Back end of the hash core: lane updates, merge and finalizer op sequence.
// Depends on tlh_pkg.
module tlh_back #(
  parameter int unsigned MAX_OPS = tlh_pkg::MaxOps
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  tlh_pkg::tlh_cmd_t cmd_i,
  input  logic [2:0]        op_count_i,
  input  logic [23:0]       op_kinds_i,
  input  logic [63:0]       op_args_i [6],
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [63:0]       digest_o
);
  import tlh_pkg::*;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StMul  = 6'b000010,
    StPrd  = 6'b000100,
    StMrg  = 6'b001000,
    StOps  = 6'b010000,
    StOut  = 6'b100000
  } state_e;

  state_e      st_q, st_d;
  logic [63:0] h_q, h_d, v_q, v_d, x_q, x_d, a_q, a_d, b_q, b_d;
  logic [63:0] pp_ll_q, prod;
  logic [31:0] pp_lh_q, pp_hl_q;
  logic [63:0] res_q, res_d, lh, lv, opx;
  logic        last_q, last_d, tov_q, tov_d, mulop_q, mulop_d;
  logic [2:0]  slot_q, slot_d, nops;
  logic [3:0]  kd;
  logic [63:0] arg;
  logic [5:0]  s;

  assign nops = (op_count_i > 3'(MAX_OPS)) ? 3'(MAX_OPS) : op_count_i;
  assign kd   = op_kinds_i[{slot_q[2:0], 2'b00} +: 4];
  assign arg  = op_args_i[slot_q];
  assign s    = arg[5:0];
  assign cmd_ready_o = st_q == StIdle;
  assign out_valid_o = st_q == StOut;
  assign digest_o    = res_q;

  // Low 64 bits of a_q * b_q from three registered 32x32 partial products.
  assign prod = pp_ll_q + {pp_lh_q + pp_hl_q, 32'd0};

  always_comb begin
    case (kd)
      OpXsl:    opx = x_q ^ (x_q << s);
      OpXsr:    opx = x_q ^ (x_q >> s);
      OpXorRor: opx = x_q ^ rotr64(x_q, s);
      OpAdd:    opx = x_q + arg;
      OpXor:    opx = x_q ^ arg;
      OpNot:    opx = ~x_q;
      OpBswap:  opx = {<<8{x_q}};
      OpAddShl: opx = x_q + (x_q << s);
      OpSubShl: opx = x_q - (x_q << s);
      OpSub:    opx = x_q - arg;
      OpRol:    opx = rotl64(x_q, s);
      default:  opx = x_q;
    endcase
  end

  always_comb begin
    st_d = st_q; h_d = h_q; v_d = v_q; x_d = x_q; a_d = a_q; b_d = b_q;
    res_d = res_q; last_d = last_q; tov_d = tov_q; slot_d = slot_q; mulop_d = mulop_q;
    lh = cmd_i.first ? cmd_i.len * HashM2 : h_q;
    lv = cmd_i.first ? {32'd0, cmd_i.len} : v_q;
    case (st_q)
      StIdle: if (cmd_valid_i) begin
        h_d = lh; v_d = lv; last_d = cmd_i.last; mulop_d = 1'b0;
        if (cmd_i.kind == AbsH) begin
          a_d = rotr64(lh, 6'd33) + cmd_i.word; b_d = HashM1; tov_d = 1'b0; st_d = StMul;
        end else if (cmd_i.kind == AbsV) begin
          a_d = rotr64(lv, 6'd37) + cmd_i.word; b_d = HashM2; tov_d = 1'b1; st_d = StMul;
        end else if (cmd_i.last) begin
          st_d = StMrg;
        end
      end
      // Partial products are registered at the end of this cycle.
      StMul: st_d = StPrd;
      StPrd: begin
        if (mulop_q) begin
          x_d = prod; slot_d = slot_q + 3'd1; st_d = StOps;
        end else begin
          if (tov_q) v_d = prod; else h_d = prod;
          st_d = last_q ? StMrg : StIdle;
        end
      end
      StMrg: begin
        a_d = rotr64(h_q, 6'd33) + v_q; b_d = HashM1;
        last_d = 1'b0; mulop_d = 1'b1;
        // The slot wraps to zero when the merge product comes back.
        slot_d = 3'd7; st_d = StMul;
      end
      StOps: begin
        if (slot_q == 3'd0) h_d = x_q;
        if (slot_q >= nops) begin
          res_d = x_q; st_d = StOut;
        end else if (kd == OpMul) begin
          a_d = x_q; b_d = arg; mulop_d = 1'b1; st_d = StMul;
        end else begin
          x_d = opx; slot_d = slot_q + 3'd1;
        end
      end
      StOut: if (out_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    pp_ll_q <= {32'd0, a_q[31:0]} * {32'd0, b_q[31:0]};
    pp_lh_q <= a_q[31:0] * b_q[63:32];
    pp_hl_q <= a_q[63:32] * b_q[31:0];
    x_q <= x_d; a_q <= a_d; b_q <= b_d; res_q <= res_d;
    last_q <= last_d; tov_q <= tov_d; mulop_q <= mulop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      slot_q <= '0;
      h_q    <= '0;
      v_q    <= '0;
    end else begin
      st_q   <= st_d;
      slot_q <= slot_d;
      h_q    <= h_d;
      v_q    <= v_d;
    end
  end

endmodule

### src/two_lane_hash_with_op_finalizer_core.sv
// Top level of the two-lane multiply-rotate hash core with op finalizer.
// Depends on tlh_pkg, tlh_front, tlh_queue and tlh_back.
//
// Usage: message words enter on the in_valid_i/in_ready_o channel, one
// 64-bit little-endian word per request, with the byte length given on the
// request that has first_word_i set. A request with last_word_i set closes
// the message; one hash request then leaves on out_valid_o/out_ready_i.
// Configuration (op count, op kinds, six op arguments) is written through
// cfg_we_i/cfg_idx_i/cfg_data_i while the core is idle.
// Throughput: the front end classifies a word per cycle into a two-entry
// queue while the queue has room; the back end takes one queued word at a
// time, passing a word that updates a lane through take, partial products,
// and sum and write back in the multiplier, and taking a skipped word in
// its idle state alone. Result path: a last word passes through the queue,
// its lane update if any, and the merge multiply, then one step per plain
// finalizer op and a multiplier pass per multiply op. The result register
// holds while the receiver stalls; the back end accepts nothing until it is
// taken, and the queue then fills and deasserts in_ready_o.
// Reset clears lane state, word position, config registers and the queue.
module two_lane_hash_with_op_finalizer_core #(
  parameter int unsigned MAX_OPS = tlh_pkg::MaxOps
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_word_i,
  input  logic [31:0] total_len_i,
  input  logic        first_word_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);
  import tlh_pkg::*;

  tlh_cmd_t    f_cmd, q_cmd;
  logic        f_valid, f_ready, q_valid, q_ready;
  logic [2:0]  op_count_q;
  logic [23:0] op_kinds_q;
  logic [63:0] op_args_q [6];

  // Configuration registers; indexes two to seven select the op arguments.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_count_q <= '0;
      op_kinds_q <= '0;
      for (int i = 0; i < 6; i++) op_args_q[i] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegOpCount) op_count_q <= cfg_data_i[2:0];
      else if (cfg_idx_i == RegOpKinds) op_kinds_q <= cfg_data_i[23:0];
      else op_args_q[cfg_idx_i - RegOpArg0] <= cfg_data_i;
    end
  end

  tlh_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .data_word_i, .total_len_i,
    .first_word_i, .last_word_i,
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd)
  );

  tlh_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_cmd),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_cmd)
  );

  tlh_back #(.MAX_OPS(MAX_OPS)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_cmd),
    .op_count_i(op_count_q), .op_kinds_i(op_kinds_q), .op_args_i(op_args_q),
    .out_valid_o, .out_ready_i, .digest_o
  );

  // A waiting result keeps its value until the receiver takes it.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(digest_o))
    else $error("result changed while stalled");
  // The back end never takes a queued word while a result waits.
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !q_ready)
    else $error("back end busy with result");

endmodule

### tb/tb_two_lane_hash_with_op_finalizer_core.sv
// Self-checking testbench for two_lane_hash_with_op_finalizer_core.
// Depends on tlh_pkg and the core; predicts each hash in SystemVerilog and
// compares it with the core's output under random idling on both channels.
module tb_two_lane_hash_with_op_finalizer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tlh_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] data_word_i = '0;
  logic [31:0] total_len_i = '0;
  logic        first_word_i = 1'b0;
  logic        last_word_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] digest_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  two_lane_hash_with_op_finalizer_core dut (.*);

  always #4 clk_i = ~clk_i;

  // Shadow of the core's lane state and configuration.
  logic [63:0] lane_h, lane_v;
  logic [29:0] word_pos;
  logic [31:0] msg_len;
  logic [2:0]  fin_count;
  logic [23:0] fin_kinds;
  logic [63:0] fin_args [6];

  logic [63:0] expected_hashes [$];
  int unsigned error_count = 0;
  bit          recv_stalls = 1'b1;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic logic [63:0] rot_r(logic [63:0] x, int unsigned s);
    s = s % 64;
    return (s == 0) ? x : ((x >> s) | (x << (64 - s)));
  endfunction

  function automatic logic [63:0] fin_op(logic [63:0] x, logic [3:0] kind,
                                         logic [63:0] arg);
    int unsigned s;
    logic [63:0] r;
    s = 32'(arg[5:0]);
    case (kind)
      OpMul:    r = x * arg;
      OpXsl:    r = x ^ (x << s);
      OpXsr:    r = x ^ (x >> s);
      OpXorRor: r = x ^ rot_r(x, s);
      OpAdd:    r = x + arg;
      OpXor:    r = x ^ arg;
      OpNot:    r = ~x;
      OpBswap:  r = {<<8{x}};
      OpAddShl: r = x + (x << s);
      OpSubShl: r = x - (x << s);
      OpSub:    r = x - arg;
      OpRol:    r = rot_r(x, (64 - s) % 64);
      default:  r = x;
    endcase
    return r;
  endfunction

  // Advances the shadow lanes by one accepted word and queues the hash
  // when the word closes a message.
  task automatic predict_word(input logic [63:0] w, input logic [31:0] len,
                              input logic f, input logic l);
    logic [31:0] full_words;
    logic [63:0] mask, h;
    int unsigned n;
    if (f) begin
      msg_len = len;
      lane_h = 64'(len) * HashM2;
      lane_v = 64'(len);
      word_pos = '0;
    end
    full_words = (msg_len >> 4) << 1;
    if (32'(word_pos) < full_words) begin
      if (!word_pos[0]) lane_h = (rot_r(lane_h, 33) + w) * HashM1;
      else lane_v = (rot_r(lane_v, 37) + w) * HashM2;
    end else if (msg_len[3] && 32'(word_pos) == full_words) begin
      lane_h = (rot_r(lane_h, 33) + w) * HashM1;
    end else if (msg_len[2:0] != 0 && 32'(word_pos) == (msg_len >> 3)) begin
      mask = (64'd1 << (8 * msg_len[2:0])) - 1;
      lane_v = (rot_r(lane_v, 37) + (w & mask)) * HashM2;
    end
    if (word_pos != IdxMax) word_pos++;
    if (l) begin
      lane_h = (rot_r(lane_h, 33) + lane_v) * HashM1;
      h = lane_h;
      n = (fin_count > MaxOps) ? MaxOps : fin_count;
      for (int i = 0; i < n; i++) h = fin_op(h, fin_kinds[4*i +: 4], fin_args[i]);
      expected_hashes.insert(expected_hashes.size(), h);
    end
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  bit send_gaps = 1'b1;

  // Offers one request and holds it until the core takes it. Valid stays
  // high between requests sent back to back.
  task automatic send_word(input logic [63:0] w, input logic [31:0] len,
                           input logic f, input logic l);
    int unsigned g;
    g = send_gaps ? gap_len() : 0;
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_word_i  <= w;
    total_len_i  <= len;
    first_word_i <= f;
    last_word_i  <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_word(w, len, f, l);
  endtask

  // Sends a message of the given length with random content; very long
  // messages are cut short by an early last word.
  task automatic send_message(input logic [31:0] len);
    int unsigned nwords;
    nwords = (len + 7) / 8;
    if (nwords == 0) nwords = 1;
    if (nwords > 8) nwords = 8;
    for (int i = 0; i < nwords; i++)
      send_word({$urandom, $urandom}, len, i == 0, i == nwords - 1);
  endtask

  // Receiver: stalls at random and checks each hash against the oldest one
  // predicted.
  initial begin
    logic [63:0] exp_h;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_hashes.size() == 0) begin
          report_mismatch($sformatf("unexpected hash %h", digest_o));
        end else begin
          exp_h = expected_hashes.pop_front();
          if (digest_o !== exp_h)
            report_mismatch($sformatf("digest got %h want %h", digest_o, exp_h));
        end
      end
      out_ready_i <= recv_stalls ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  // Writes one register, then drops the write enable again before returning.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegOpCount: fin_count = val[2:0];
      RegOpKinds: fin_kinds = val[23:0];
      default:    fin_args[idx - RegOpArg0] = val;
    endcase
  endtask

  // Drops valid, waits for every hash to arrive, then for the core to drain
  // any word that produces no result.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic load_finalizer(input logic [2:0] cnt, input logic [23:0] kinds,
                                input bit extreme_args);
    wait_idle();
    write_reg(RegOpCount, cnt);
    write_reg(RegOpKinds, kinds);
    for (int i = 0; i < 6; i++)
      write_reg(RegOpArg0 + 3'(i), extreme_args ? {64{i[0]}} : {$urandom, $urandom});
  endtask

  // Directed: lengths around block edges, empty and huge lengths, broken
  // framing, and extreme data words.
  task automatic test_directed();
    foreach (fin_args[i]) fin_args[i] = '0;
    send_word('1, 0, 1'b1, 1'b1);
    send_message(1);
    send_message(7);
    send_message(8);
    send_message(15);
    send_message(16);
    send_message(24);
    send_message(31);
    send_word('0, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_word('1, 32'hFFFF_FFFF, 1'b0, 1'b1);
    send_word(64'h0123_4567_89ab_cdef, 20, 1'b1, 1'b1);
    send_word('1, 0, 1'b0, 1'b1);
    send_word('1, 5, 1'b1, 1'b0);
    send_word('1, 5, 1'b0, 1'b0);
    send_word('1, 5, 1'b0, 1'b0);
    send_word(64'h5555_aaaa_5555_aaaa, 5, 1'b0, 1'b1);
  endtask

  // Each op code alone, with a shift amount of 0 (even codes) or 63 (odd codes) and then a random one.
  task automatic test_each_op();
    for (int k = 0; k < 16; k++) begin
      load_finalizer(3'd1, 24'(k), 1'b0);
      write_reg(RegOpArg0, k[0] ? 64'd63 : 64'd0);
      send_message($urandom_range(0, 40));
      wait_idle();
      write_reg(RegOpArg0, {$urandom, $urandom});
      send_message($urandom_range(0, 40));
    end
  endtask

  // Random chains of ops with random messages, some broken framing and
  // a stretch without idling.
  task automatic test_random_messages();
    for (int p = 0; p < 12; p++) begin
      if (p == 0) load_finalizer(3'd7, 24'hFFFFFF, 1'b1);
      else if (p == 1) load_finalizer(3'd6, 24'h000000, 1'b1);
      else load_finalizer(3'($urandom_range(0, 7)), 24'($urandom), 1'b0);
      send_gaps = (p != 3);
      recv_stalls = (p != 3);
      for (int m = 0; m < 42; m++) begin
        if ($urandom_range(0, 9) == 0)
          send_word({$urandom, $urandom}, $urandom, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        else if ($urandom_range(0, 19) == 0)
          send_message($urandom);
        else
          send_message($urandom_range(0, 40));
      end
    end
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_each_op();
    test_random_messages();
    wait_idle();
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  // Huge lengths would take 2^29 words; send_message caps them first.
endmodule
